@@ sv/fulut_pkg.sv @@
// ----------------------------------------------------------------------------
// fulut_pkg
// Shared types and constants for the first unique letter tracker.
// ----------------------------------------------------------------------------
package fulut_pkg;

    // letters in the alphabet, one list slot per letter
    localparam int Alphabet = 26;
    localparam int LetterW  = 5;
    localparam int IdxW     = $clog2(Alphabet);
    localparam int CountW   = 2;

    localparam logic [CountW-1:0] CountNone = 2'd0;
    localparam logic [CountW-1:0] CountOnce = 2'd1;
    localparam logic [CountW-1:0] CountMany = 2'd2;

    // list update broadcast to every cell
    typedef struct packed {
        logic               clear;
        logic               append;
        logic               remove;
        logic [LetterW-1:0] letter;
    } t_op;

    // content of one list slot
    typedef struct packed {
        logic               valid;
        logic [LetterW-1:0] letter;
    } t_slot;

endpackage

@@ sv/first_unique_letter_tracker_core.sv @@
// ----------------------------------------------------------------------------
// first_unique_letter_tracker_core
// Reports, per letter, the earliest letter seen exactly once in the stream.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                   | tuser
//  s_axis   | in  | [4:0] letter            | new_stream
//  m_axis   | out | [4:0] first_unique      | found
//
//  One transaction per cycle while the output is not stalled: the count
//  lookup, the list update over the cell row and the head pick all settle
//  in the cycle the letter is accepted; the ripple of the removal shift
//  through the cell row sets the path. Input is taken whenever the output
//  register is empty or drained in the same cycle. Synchronous active-low
//  reset empties the list, zeroes the counts and drops the output register.
// ----------------------------------------------------------------------------
module first_unique_letter_tracker_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // [4:0] letter, [7:5] zero
    input  logic       i_s_axis_tuser,  // [0] new_stream
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,  // [4:0] first_unique, [7:5] zero
    output logic       o_m_axis_tuser   // [0] found
);

    logic [fulut_pkg::CountW-1:0]  r_count [fulut_pkg::Alphabet];
    logic                          r_out_valid;
    logic                          r_found;
    logic [fulut_pkg::LetterW-1:0] r_first;

    logic                          accept;
    logic [fulut_pkg::LetterW-1:0] letter;
    logic [fulut_pkg::IdxW-1:0]    idx;
    logic                          in_range;
    logic [fulut_pkg::CountW-1:0]  cur_count;
    fulut_pkg::t_op                op;
    fulut_pkg::t_slot              head_next;

    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;

    assign letter   = i_s_axis_tdata[fulut_pkg::LetterW-1:0];
    assign idx      = fulut_pkg::IdxW'(letter);
    assign in_range = int'(letter) < fulut_pkg::Alphabet;

    // count after any stream clear
    assign cur_count = (i_s_axis_tuser || !in_range) ? fulut_pkg::CountNone : r_count[idx];

    always_comb begin
        op.clear  = i_s_axis_tuser;
        op.append = in_range & (cur_count == fulut_pkg::CountNone);
        op.remove = in_range & (cur_count == fulut_pkg::CountOnce);
        op.letter = letter;
    end

    fulut_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (accept),
        .i_op        (op),
        .o_head_next (head_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < fulut_pkg::Alphabet; k++) begin
                r_count[k] <= fulut_pkg::CountNone;
            end
        end else if (accept) begin
            for (int k = 0; k < fulut_pkg::Alphabet; k++) begin
                if (in_range && (int'(idx) == k)) begin
                    r_count[k] <= (cur_count == fulut_pkg::CountNone) ?
                                  fulut_pkg::CountOnce : fulut_pkg::CountMany;
                end else if (i_s_axis_tuser) begin
                    r_count[k] <= fulut_pkg::CountNone;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_found <= head_next.valid;
            r_first <= head_next.valid ? head_next.letter : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(8 - fulut_pkg::LetterW){1'b0}}, r_first};
    assign o_m_axis_tuser  = r_found;

endmodule

@@ sv/fulut_cell.sv @@
// ----------------------------------------------------------------------------
// fulut_cell
// One slot of the arrival-ordered list. Takes the shift from its right
// neighbor when a removal hits here or further left, or takes an append when
// it is the first free slot.
// ----------------------------------------------------------------------------
module fulut_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  fulut_pkg::t_op   i_op,
    input  logic             i_prev_valid,
    input  fulut_pkg::t_slot i_right,
    input  logic             i_shift,
    output fulut_pkg::t_slot o_slot,
    output logic             o_shift,
    output fulut_pkg::t_slot o_next
);

    logic                          r_valid;
    logic [fulut_pkg::LetterW-1:0] r_letter;
    logic                          match;

    // slot content after any stream clear
    assign o_slot.valid  = r_valid & ~i_op.clear;
    assign o_slot.letter = r_letter;

    assign match   = i_op.remove & o_slot.valid & (r_letter == i_op.letter);
    assign o_shift = i_shift | match;

    always_comb begin
        if (o_shift) begin
            o_next = i_right;
        end else if (i_op.append & ~o_slot.valid & i_prev_valid) begin
            o_next.valid  = 1'b1;
            o_next.letter = i_op.letter;
        end else begin
            o_next = o_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= o_next.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_letter <= o_next.letter;
        end
    end

endmodule

@@ sv/fulut_chain.sv @@
// ----------------------------------------------------------------------------
// fulut_chain
// Row of list cells, slot 0 the earliest. Exposes the next head slot.
// ----------------------------------------------------------------------------
module fulut_chain (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  fulut_pkg::t_op   i_op,
    output fulut_pkg::t_slot o_head_next
);

    fulut_pkg::t_slot slot_eff  [fulut_pkg::Alphabet];
    fulut_pkg::t_slot slot_next [fulut_pkg::Alphabet];
    logic             shift     [fulut_pkg::Alphabet+1];

    assign shift[0] = 1'b0;

    for (genvar g = 0; g < fulut_pkg::Alphabet; g++) begin : g_cell
        logic             prev_valid;
        fulut_pkg::t_slot right;

        if (g == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_mid
            assign prev_valid = slot_eff[g-1].valid;
        end

        if (g == fulut_pkg::Alphabet - 1) begin : g_last
            assign right = '0;
        end else begin : g_inner
            assign right = slot_eff[g+1];
        end

        fulut_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_advance    (i_advance),
            .i_op         (i_op),
            .i_prev_valid (prev_valid),
            .i_right      (right),
            .i_shift      (shift[g]),
            .o_slot       (slot_eff[g]),
            .o_shift      (shift[g+1]),
            .o_next       (slot_next[g])
        );
    end

    assign o_head_next = slot_next[0];

endmodule
